// ===== src/baro_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths and register indexes for the compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

    localparam int unsigned RAW_W  = 20;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned QUO_W  = 32;

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_9 = 2'd3;

    typedef logic [WORD_W-1:0] t_word;

endpackage

// ===== src/baro_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Fully pipelined 32-bit integer compensation of raw sensor samples.
// ----------------------------------------------------------------------------
// A transaction starts when i_start is high while o_busy is low; o_busy is
// always low, so one sample pair may enter on every clock cycle.
// Calibration is written over a valid/ready channel with an index and data;
// o_cfg_ready is always high, and the sender must write only while no
// transaction is in flight; the block itself does not enforce it.
// Each result appears for one cycle with o_valid high. From the accepting
// edge to the edge that raises o_valid, a sample passes eleven multiply
// stages, the 32-step restoring divider, which retires one quotient
// bit per pipeline stage, and three correction stages.
// The receiver cannot stall, so the pipeline never holds back.
// A synchronous active-low reset clears the valid bits and the calibration.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [baro_pkg::RAW_W-1:0]  i_raw_temperature,
    input  logic [baro_pkg::RAW_W-1:0]  i_raw_pressure,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [63:0]                 i_cfg_data,
    output logic                        o_valid,
    output logic signed [31:0]          o_temperature_centi,
    output logic [31:0]                 o_pressure_pa,
    output logic                        o_pressure_invalid
);
    import baro_pkg::*;

    localparam int FS = 11;
    localparam int DS = QUO_W;

    logic [47:0] r_tc;
    logic [63:0] r_pa, r_pb;
    logic [15:0] r_p9;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pa <= '0;
            r_pb <= '0;
            r_p9 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP:    r_tc <= i_cfg_data[47:0];
                REG_PRESS_A: r_pa <= i_cfg_data;
                REG_PRESS_B: r_pb <= i_cfg_data;
                REG_PRESS_9: r_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    function automatic t_word sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_word asr(input t_word x, input int n);
        return t_word'($signed(x) >>> n);
    endfunction

    t_word t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = sx(r_tc[31:16]);
    assign t3 = sx(r_tc[47:32]);
    assign p1 = {16'd0, r_pa[15:0]};
    assign p2 = sx(r_pa[31:16]);
    assign p3 = sx(r_pa[47:32]);
    assign p4 = sx(r_pa[63:48]);
    assign p5 = sx(r_pb[15:0]);
    assign p6 = sx(r_pb[31:16]);
    assign p7 = sx(r_pb[47:32]);
    assign p8 = sx(r_pb[63:48]);
    assign p9 = sx(r_p9);

    logic [FS-1:0] r_v;
    t_word r_at;
    t_word r_ap[8];
    t_word r_x1, r_x2, r_x3, r_x4, r_fine, r_a, r_q, r_qq;
    t_word r_tmp[4:10];
    t_word r_c1, r_c2, r_b2, r_c3, r_b3, r_a4, r_div, r_div2, r_num, r_num2;
    logic  r_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[FS-2:0], i_start};
    end

    always_ff @(posedge i_clk) begin
        r_at    <= {12'd0, i_raw_temperature};
        r_ap[0] <= {12'd0, i_raw_pressure};
        for (int k = 1; k < 8; k++) begin
            r_ap[k] <= r_ap[k-1];
        end
        // Stage 1: temperature differences and products.
        r_x1 <= ((r_at >> 3) - (t1 << 1)) * t2;
        r_x2 <= ((r_at >> 4) - t1) * ((r_at >> 4) - t1);
        // Stage 2.
        r_x3 <= asr(r_x1, 11);
        r_x4 <= asr(r_x2, 12) * t3;
        // Stage 3: fine temperature.
        r_fine <= r_x3 + asr(r_x4, 14);
        // Stage 4.
        r_tmp[4] <= asr(r_fine * 32'd5 + 32'd128, 8);
        r_a <= asr(r_fine, 1) - 32'd64000;
        r_q <= asr(asr(r_fine, 1) - 32'd64000, 2);
        // Stage 5.
        r_tmp[5] <= r_tmp[4];
        r_qq <= r_q * r_q;
        r_c1 <= (r_a * p5) << 1;
        r_c2 <= asr(p2 * r_a, 1);
        // Stage 6.
        r_tmp[6] <= r_tmp[5];
        r_b2 <= asr(r_qq, 11) * p6 + r_c1;
        r_c3 <= asr(p3 * asr(r_qq, 13), 3) + r_c2;
        // Stage 7.
        r_tmp[7] <= r_tmp[6];
        r_b3 <= asr(r_b2, 2) + (p4 << 16);
        r_a4 <= 32'd32768 + asr(r_c3, 18);
        // Stage 8.
        r_tmp[8] <= r_tmp[7];
        r_div <= asr(r_a4 * p1, 15);
        r_num <= (32'd1048576 - r_ap[7]) - asr(r_b3, 12);
        // Stage 9.
        r_tmp[9] <= r_tmp[8];
        r_num2 <= r_num * 32'd3125;
        r_div2 <= r_div;
    end

    // Stage 10: dividend selection.
    t_word r_dvd, r_dsr;
    always_ff @(posedge i_clk) begin
        r_tmp[10] <= r_tmp[9];
        r_big <= r_num2[31];
        r_dvd <= r_num2[31] ? r_num2 : (r_num2 << 1);
        r_dsr <= r_div2;
    end

    // Restoring divider, one quotient bit per stage.
    logic [DS:0]  d_v;
    t_word        d_q[DS+1], d_d[DS+1], d_t[DS+1];
    logic [32:0]  d_r[DS+1];
    logic         d_b[DS+1];
    assign d_v[0] = r_v[FS-1];
    assign d_q[0] = r_dvd;
    assign d_d[0] = r_dsr;
    assign d_t[0] = r_tmp[10];
    assign d_r[0] = '0;
    assign d_b[0] = r_big;

    for (genvar g = 0; g < DS; g++) begin : g_div
        logic [32:0] s, df;
        logic [32:0] r_r;
        t_word       r_qq2, r_dd, r_tt;
        logic        r_bb, r_vv;
        assign s  = {d_r[g][31:0], d_q[g][31]};
        assign df = s - {1'b0, d_d[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vv <= 1'b0;
            else          r_vv <= d_v[g];
        end
        always_ff @(posedge i_clk) begin
            r_r   <= df[32] ? s : df;
            r_qq2 <= {d_q[g][30:0], ~df[32]};
            r_dd  <= d_d[g];
            r_tt  <= d_t[g];
            r_bb  <= d_b[g];
        end
        assign d_v[g+1] = r_vv;
        assign d_r[g+1] = r_r;
        assign d_q[g+1] = r_qq2;
        assign d_d[g+1] = r_dd;
        assign d_t[g+1] = r_tt;
        assign d_b[g+1] = r_bb;
    end

    // Post stages: correction terms.
    t_word r_p, r_e1, r_e2, r_t1, r_t2, r_t3;
    logic  r_inv, r_inv2, r_inv3, r_w1, r_w2, r_w3;
    t_word pq;
    assign pq = d_b[DS] ? (d_q[DS] << 1) : d_q[DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= 1'b0;
            r_w2 <= 1'b0;
            r_w3 <= 1'b0;
        end else begin
            r_w1 <= d_v[DS];
            r_w2 <= r_w1;
            r_w3 <= r_w2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= pq;
        r_e1   <= (pq >> 3) * (pq >> 3);
        r_t1   <= d_t[DS];
        r_inv  <= (d_d[DS] == '0);
        r_e2   <= asr(p9 * (r_e1 >> 13), 12) + asr((r_p >> 2) * p8, 13);
        r_t2   <= r_t1;
        r_inv2 <= r_inv;
        r_t3   <= r_t2;
        r_inv3 <= r_inv2;
    end

    t_word r_p2, r_p3;
    always_ff @(posedge i_clk) begin
        r_p2 <= r_p;
        r_p3 <= r_p2 + asr(r_e2 + p7, 4);
    end

    assign o_valid             = r_w3;
    assign o_temperature_centi = r_t3;
    assign o_pressure_pa       = r_inv3 ? '0 : r_p3;
    assign o_pressure_invalid  = r_inv3;

endmodule

// ===== dv/baro_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Watches the sample, calibration and result channels of the compensation
// block. It keeps its own copy of the calibration and computes the expected
// temperature and pressure for each accepted sample pair. Each result is
// then compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module baro_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [baro_pkg::RAW_W-1:0]  i_raw_temperature,
    input  logic [baro_pkg::RAW_W-1:0]  i_raw_pressure,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [63:0]                 i_cfg_data,
    input  logic                        i_valid,
    input  logic signed [31:0]          i_temperature_centi,
    input  logic [31:0]                 i_pressure_pa,
    input  logic                        i_pressure_invalid,
    output int                          o_fail_count,
    output int                          o_pending
);
    import baro_pkg::*;

    typedef struct {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic               pressure_invalid;
    } t_reading;

    logic [47:0] temp_coeffs;
    logic [63:0] press_coeffs_a;
    logic [63:0] press_coeffs_b;
    logic [15:0] press_coeff_nine;
    t_reading    readings_due[$];

    function automatic t_word asr(input t_word x, input int n);
        return t_word'($signed(x) >>> n);
    endfunction

    function automatic t_word sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_reading compensate(input logic [19:0] raw_t,
                                            input logic [19:0] raw_p);
        t_word t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t_word at, ap, a, b, d, fine, q, qq, p;
        t_reading r;
        t1 = {16'd0, temp_coeffs[15:0]};
        t2 = sext16(temp_coeffs[31:16]);
        t3 = sext16(temp_coeffs[47:32]);
        p1 = {16'd0, press_coeffs_a[15:0]};
        p2 = sext16(press_coeffs_a[31:16]);
        p3 = sext16(press_coeffs_a[47:32]);
        p4 = sext16(press_coeffs_a[63:48]);
        p5 = sext16(press_coeffs_b[15:0]);
        p6 = sext16(press_coeffs_b[31:16]);
        p7 = sext16(press_coeffs_b[47:32]);
        p8 = sext16(press_coeffs_b[63:48]);
        p9 = sext16(press_coeff_nine);
        at = {12'd0, raw_t};
        ap = {12'd0, raw_p};
        a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = asr(asr(d * d, 12) * t3, 14);
        fine = a + b;
        r.temperature_centi = asr(fine * 32'd5 + 32'd128, 8);
        a = asr(fine, 1) - 32'd64000;
        q = asr(a, 2);
        qq = q * q;
        b = asr(qq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(p3 * asr(qq, 13), 3) + asr(p2 * a, 1), 18);
        a = asr((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            r.pressure_pa = 32'd0;
            r.pressure_invalid = 1'b1;
            return r;
        end
        p = ((32'd1048576 - ap) - asr(b, 12)) * 32'd3125;
        if (p < 32'h8000_0000) begin
            p = (p << 1) / a;
        end else begin
            p = (p / a) * 32'd2;
        end
        a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
        b = asr((p >> 2) * p8, 13);
        r.pressure_pa = p + asr(a + b + p7, 4);
        r.pressure_invalid = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
    end

    assign o_pending = readings_due.size();

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            temp_coeffs <= '0;
            press_coeffs_a <= '0;
            press_coeffs_b <= '0;
            press_coeff_nine <= '0;
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TEMP:    temp_coeffs <= i_cfg_data[47:0];
                    REG_PRESS_A: press_coeffs_a <= i_cfg_data;
                    REG_PRESS_B: press_coeffs_b <= i_cfg_data;
                    REG_PRESS_9: press_coeff_nine <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                readings_due.push_back(compensate(i_raw_temperature, i_raw_pressure));
            end
            if (i_valid) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = readings_due.pop_front();
                    if (i_temperature_centi !== want.temperature_centi)
                        report_mismatch($sformatf("temperature %0d, expected %0d",
                            i_temperature_centi, want.temperature_centi));
                    if (i_pressure_pa !== want.pressure_pa)
                        report_mismatch($sformatf("pressure %0d, expected %0d",
                            i_pressure_pa, want.pressure_pa));
                    if (i_pressure_invalid !== want.pressure_invalid)
                        report_mismatch($sformatf("invalid flag %b, expected %b",
                            i_pressure_invalid, want.pressure_invalid));
                end
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives sample pairs in random bursts through several calibration sets,
// from all zero to all ones and typical factory values, and lets the
// checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb;
    import baro_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        o_valid;
    logic signed [31:0] o_temperature_centi;
    logic [31:0] o_pressure_pa;
    logic        o_pressure_invalid;
    int          fail_count;
    int          pending;
    int          cycles;

    baro_temp_pressure_compensation u_dut (.*);

    baro_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_raw_temperature(i_raw_temperature), .i_raw_pressure(i_raw_pressure),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_temperature_centi(o_temperature_centi),
        .i_pressure_pa(o_pressure_pa), .i_pressure_invalid(o_pressure_invalid),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(input logic [19:0] raw_t, input logic [19:0] raw_p);
        bit taken;
        i_start <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure <= raw_p;
        do begin
            taken = !o_busy;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do begin
            taken = o_cfg_ready;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic load_calibration(input logic [47:0] temp_set, input logic [63:0] press_a,
                                    input logic [63:0] press_b, input logic [63:0] nine);
        i_start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(REG_TEMP, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000
                  | {16'd0, temp_set});
        write_reg(REG_PRESS_A, press_a);
        write_reg(REG_PRESS_B, press_b);
        write_reg(REG_PRESS_9, nine);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_burst_run(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if ($urandom_range(0, 3) == 0)
                    send_sample(20'($urandom), 20'($urandom));
                else
                    send_sample(20'(20'd519888 + $urandom_range(0, 65535) - 20'd32768),
                                20'(20'd415148 + $urandom_range(0, 131071) - 20'd65536));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset calibration gives a zero divisor on every transaction.
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        random_burst_run(100);

        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                         {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 64'd6000);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h80000, 20'h7FFFF);
        send_sample(20'h7FFFF, 20'h80000);
        send_sample(20'hAAAAA, 20'h55555);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'd519888, 20'd415148);
        i_start <= 1'b0;
        @(negedge i_clk);
        random_burst_run(500);

        load_calibration('1, '1, '1, 64'hFFFF);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        random_burst_run(200);

        load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {48'h8000_8000_8000, 16'hFFFF},
                         64'h8000_8000_8000_8000, 64'h8000);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        random_burst_run(200);

        load_calibration({16'h7FFF, 16'h7FFF, 16'h0000}, {48'h7FFF_7FFF_7FFF, 16'h0001},
                         64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
        random_burst_run(200);

        repeat (4) begin
            load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom});
            random_burst_run(200);
        end

        i_start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
